// ----- rtl/m4m_pkg.sv -----
// m4m_pkg: shared constants, types and control structs of the 4x4 matrix multiplier
// no dependencies; used by every rtl file of the block except m4m_ram
`timescale 1ns / 1ps

package m4m_pkg;

    // matrix size and fixed-point format
    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = DIM * DIM;

    // field widths
    localparam int IDX_W    = 4;
    localparam int VAL_W    = 32;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int ACC_W    = PROD_W + $clog2(DIM);
    localparam int LANE_W   = $clog2(DIM);
    localparam int HALF     = DIM / 2;

    // packed stream widths
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 40;

    typedef logic        [IDX_W-1:0]  idx_t;
    typedef logic        [LANE_W-1:0] lane_idx_t;
    typedef logic signed [VAL_W-1:0]  value_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam value_t SAT_MAX = 32'sh7FFF_FFFF;
    localparam value_t SAT_MIN = 32'sh8000_0000;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // element pair write into the lane banks
    typedef struct packed {
        logic      valid;
        lane_idx_t row;
        lane_idx_t col;
        value_t    left;
        value_t    right;
    } elem_wr_t;

    // read issue and pipeline advance shared by all lanes
    typedef struct packed {
        logic      issue;
        logic      advance;
        lane_idx_t row;
        lane_idx_t col;
    } rd_ctl_t;

endpackage

// ----- rtl/matrix4_multiply.sv -----
// matrix4_multiply: top level of the 4x4 signed q16.16 matrix multiplier
// depends on m4m_pkg, m4m_lane (with m4m_ram) and m4m_merge
`timescale 1ns / 1ps

// Each input item carries one element pair (left and right matrix) at a flat row-major
// index; the pair is written into per-lane element banks in the cycle it is accepted.
// The item with index 15 starts a run: the sequencer walks the 16 product positions, one
// per cycle unless m_tready stalls, and for each one the four lanes read left[i][k] and
// right[k][j] from their own banks and multiply them; the merge stage adds the four exact
// 64-bit products in a wide accumulator, shifts right by 16 (toward minus infinity) and
// saturates to 32 bits. Results leave in row-major order, m_tlast marks the sixteenth.
// Items load one per cycle while idle; during the issue of a run s_tready is low. The
// first result passes the bank read, multiply, half sum and final add and saturate
// registers after the final item is accepted, and the next matrix pair may load while
// the pipeline drains. A stalled m_tready freezes the whole pipeline and the walk of
// the sequencer. Entries of the banks hold their last written values across runs
// and reset; a run that reads an entry never written gives undefined data.
module matrix4_multiply (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input item
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [m4m_pkg::S_DATA_W-1:0]   s_tdata,   // elem_index[3:0], left_value[35:4],
                                                      // right_value[67:36], zero pad
    // result item
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [m4m_pkg::M_DATA_W-1:0]   m_tdata,   // product_value[31:0],
                                                      // product_index[35:32], zero pad
    output logic                           m_tlast    // last_element
);

    // input unpack
    m4m_pkg::idx_t   in_idx;
    m4m_pkg::value_t in_left;
    m4m_pkg::value_t in_right;
    logic            in_accept;

    assign in_idx    = s_tdata[m4m_pkg::IDX_W-1:0];
    assign in_left   = s_tdata[m4m_pkg::IDX_W +: m4m_pkg::VAL_W];
    assign in_right  = s_tdata[m4m_pkg::IDX_W + m4m_pkg::VAL_W +: m4m_pkg::VAL_W];
    assign in_accept = s_tvalid && s_tready;

    // sequencer state
    m4m_pkg::state_t state_reg;
    m4m_pkg::state_t state_next;
    m4m_pkg::idx_t   pos_reg;
    m4m_pkg::idx_t   pos_next;

    // pipeline valids and position tags
    logic            v1_reg, v2_reg, v3_reg, out_valid_reg;
    m4m_pkg::idx_t   p1_reg, p2_reg, p3_reg, out_pos_reg;

    logic            advance;
    logic            issue;
    logic            in_range;
    logic            is_final;

    m4m_pkg::elem_wr_t wr;
    m4m_pkg::rd_ctl_t  rd;
    m4m_pkg::prod_t    lane_prod [m4m_pkg::DIM];
    m4m_pkg::value_t   result;

    // whole pipeline moves when the output register is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign issue    = (state_reg == m4m_pkg::ST_RUN) && advance;
    assign s_tready = (state_reg == m4m_pkg::ST_IDLE);

    // indexes beyond the matrix are dropped
    assign in_range = ({1'b0, in_idx} < (m4m_pkg::IDX_W + 1)'(m4m_pkg::CELLS));
    assign is_final = (in_idx == m4m_pkg::idx_t'(m4m_pkg::CELLS - 1));

    always_comb begin
        wr.valid = in_accept && in_range;
        wr.row   = m4m_pkg::lane_idx_t'(in_idx / m4m_pkg::DIM);
        wr.col   = m4m_pkg::lane_idx_t'(in_idx % m4m_pkg::DIM);
        wr.left  = in_left;
        wr.right = in_right;
    end

    always_comb begin
        rd.issue   = issue;
        rd.advance = advance;
        rd.row     = m4m_pkg::lane_idx_t'(pos_reg / m4m_pkg::DIM);
        rd.col     = m4m_pkg::lane_idx_t'(pos_reg % m4m_pkg::DIM);
    end

    // next state: a final item starts a run, the run ends after the last position
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            m4m_pkg::ST_IDLE: begin
                if (in_accept && in_range && is_final) begin
                    state_next = m4m_pkg::ST_RUN;
                    pos_next   = '0;
                end
            end
            m4m_pkg::ST_RUN: begin
                if (advance) begin
                    pos_next = pos_reg + m4m_pkg::idx_t'(1);
                    if (pos_reg == m4m_pkg::idx_t'(m4m_pkg::CELLS - 1)) begin
                        state_next = m4m_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = m4m_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= m4m_pkg::ST_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // valid bits follow the data through read, multiply, half sum and output stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // position tags carry no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_reg      <= pos_reg;
            p2_reg      <= p1_reg;
            p3_reg      <= p2_reg;
            out_pos_reg <= p3_reg;
        end
    end

    // product lanes, lane k owns term k of every dot product
    for (genvar k = 0; k < m4m_pkg::DIM; k++) begin : g_lane
        m4m_lane u_lane (
            .aclk    (aclk),
            .lane_id (m4m_pkg::lane_idx_t'(k)),
            .wr      (wr),
            .rd      (rd),
            .prod    (lane_prod[k])
        );
    end

    m4m_merge u_merge (
        .aclk    (aclk),
        .advance (advance),
        .prod    (lane_prod),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(m4m_pkg::M_DATA_W - m4m_pkg::VAL_W - m4m_pkg::IDX_W){1'b0}},
                       out_pos_reg, result};
    assign m_tlast  = (out_pos_reg == m4m_pkg::idx_t'(m4m_pkg::CELLS - 1));

endmodule

// ----- rtl/m4m_ram.sv -----
// m4m_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module m4m_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/m4m_lane.sv -----
// m4m_lane: one product lane, holding column k of the left matrix and row k of the right
// depends on m4m_pkg and m4m_ram
`timescale 1ns / 1ps

module m4m_lane (
    input  logic                aclk,
    input  m4m_pkg::lane_idx_t  lane_id,
    input  m4m_pkg::elem_wr_t   wr,
    input  m4m_pkg::rd_ctl_t    rd,
    output m4m_pkg::prod_t      prod
);

    logic [m4m_pkg::VAL_W-1:0] left_q;
    logic [m4m_pkg::VAL_W-1:0] right_q;
    m4m_pkg::prod_t            prod_reg;

    // left bank: entry row of column lane_id
    m4m_ram #(
        .WIDTH (m4m_pkg::VAL_W),
        .DEPTH (m4m_pkg::DIM)
    ) u_left_bank (
        .clk   (aclk),
        .we    (wr.valid && (wr.col == lane_id)),
        .waddr (wr.row),
        .wdata (wr.left),
        .re    (rd.issue),
        .raddr (rd.row),
        .rdata (left_q)
    );

    // right bank: entry col of row lane_id
    m4m_ram #(
        .WIDTH (m4m_pkg::VAL_W),
        .DEPTH (m4m_pkg::DIM)
    ) u_right_bank (
        .clk   (aclk),
        .we    (wr.valid && (wr.row == lane_id)),
        .waddr (wr.col),
        .wdata (wr.right),
        .re    (rd.issue),
        .raddr (rd.col),
        .rdata (right_q)
    );

    // signed 32 by 32 multiply, full 64-bit product
    always_ff @(posedge aclk) begin
        if (rd.advance) begin
            prod_reg <= $signed(left_q) * $signed(right_q);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/m4m_merge.sv -----
// m4m_merge: sums the lane products over two stages, scales and saturates to 32 bits
// depends on m4m_pkg
`timescale 1ns / 1ps

module m4m_merge (
    input  logic                aclk,
    input  logic                advance,
    input  m4m_pkg::prod_t      prod [m4m_pkg::DIM],
    output m4m_pkg::value_t     result
);

    m4m_pkg::acc_t   lo_reg;
    m4m_pkg::acc_t   lo_next;
    m4m_pkg::acc_t   hi_reg;
    m4m_pkg::acc_t   hi_next;
    m4m_pkg::acc_t   total;
    m4m_pkg::acc_t   scaled;
    m4m_pkg::value_t result_reg;
    m4m_pkg::value_t result_next;

    // stage a: two half sums
    always_comb begin
        lo_next = '0;
        hi_next = '0;
        for (int k = 0; k < m4m_pkg::DIM; k++) begin
            if (k < m4m_pkg::HALF) begin
                lo_next = lo_next + m4m_pkg::acc_t'(prod[k]);
            end else begin
                hi_next = hi_next + m4m_pkg::acc_t'(prod[k]);
            end
        end
    end

    // stage b: final add, arithmetic shift, saturate
    always_comb begin
        total  = lo_reg + hi_reg;
        scaled = total >>> m4m_pkg::FRAC_BITS;
        if ((&scaled[m4m_pkg::ACC_W-1:m4m_pkg::VAL_W-1])
                || !(|scaled[m4m_pkg::ACC_W-1:m4m_pkg::VAL_W-1])) begin
            result_next = scaled[m4m_pkg::VAL_W-1:0];
        end else if (scaled[m4m_pkg::ACC_W-1]) begin
            result_next = m4m_pkg::SAT_MIN;
        end else begin
            result_next = m4m_pkg::SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- rtl/m4m_checker.sv -----
// m4m_checker: port-level assertions for matrix4_multiply, bound to the top level
// depends on m4m_pkg and matrix4_multiply
`timescale 1ns / 1ps

module m4m_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [m4m_pkg::S_DATA_W-1:0]  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [m4m_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tlast
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result item changed");

    // tlast exactly on the final product position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[m4m_pkg::VAL_W +: m4m_pkg::IDX_W]
                                  == m4m_pkg::idx_t'(m4m_pkg::CELLS - 1))))
        else $error("m_tlast does not match product index");

    // a final item starts a run: s_tready drops once it is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready
            && (s_tdata[m4m_pkg::IDX_W-1:0] == m4m_pkg::idx_t'(m4m_pkg::CELLS - 1))
        |=> !s_tready)
        else $error("input accepted while a run is issuing");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // consecutive results of a run step through the positions in order
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid
        |-> m_tdata[m4m_pkg::VAL_W +: m4m_pkg::IDX_W]
            == $past(m_tdata[m4m_pkg::VAL_W +: m4m_pkg::IDX_W]) + m4m_pkg::idx_t'(1))
        else $error("product positions out of order");

endmodule

bind matrix4_multiply m4m_checker u_m4m_checker (.*);
